[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on a rising edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Simple implication or expression check, disabled by active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that an expression is never true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[design/lfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfr_pkg
// Constants, types and helper functions for the LIN frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

  // Fixed protocol bytes
  localparam logic [7:0] BREAK_BYTE = 8'h00;
  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] ID_MASK    = 8'h3F;

  // Storage sizes fixed by the result format
  localparam int unsigned DATA_SLOTS = 8;

  // Error codes, lowest nonzero wins
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_SYNC     = 2'd1;
  localparam logic [1:0] ERR_PARITY   = 2'd2;
  localparam logic [1:0] ERR_CHECKSUM = 2'd3;

  // Register map (index = byte address / 4)
  localparam logic REG_DATA_LENGTH = 1'b0;

  typedef logic [7:0] byte_t;

  // Result beat, first field in the highest bits
  typedef struct packed {
    logic [1:0] error_code;
    byte_t      data_7;
    byte_t      data_6;
    byte_t      data_5;
    byte_t      data_4;
    byte_t      data_3;
    byte_t      data_2;
    byte_t      data_1;
    byte_t      data_0;
    logic [5:0] frame_id;
    byte_t      protected_id;
  } result_t;

  // PID with both parity bits rebuilt from its six identifier bits
  function automatic byte_t pid_with_parity(input byte_t pid);
    logic p0;
    logic p1;
    p0 = pid[0] ^ pid[1] ^ pid[2] ^ pid[4];
    p1 = ~(pid[1] ^ pid[3] ^ pid[4] ^ pid[5]);
    return {p1, p0, pid[5:0]};
  endfunction

  // Ones' complement style add: carry wrapped back into bit 0
  function automatic byte_t add_carry(input byte_t a, input byte_t b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

[design/lin_frame_receiver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lin_frame_receiver_top
// Receives UART bytes, frames them as break/sync/PID/data/checksum and emits
// one result beat per frame with PID, data bytes and an error code.
// ----------------------------------------------------------------------------
//  Channel | Direction | Width | Contents
//  in_     | slave     |   8   | rx_byte
//  out_    | master    |  80   | result beat, see out_tdata
//  cfg_    | APB       |  32   | data_length at byte address 0
//
//  One byte is taken per cycle; each byte updates the frame state in the
//  accepting cycle; the result is registered and valid in the cycle after.
//  A frame is 4 + clamped data_length beats (break, sync, PID, data, sum).
//  in_tready drops only while a finished result waits and out_tready is low.
//  Reset (synchronous, rst_n low) returns to idle with data_length = 2.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lin_frame_receiver_top #(
  parameter int unsigned MAX_DATA_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [7:0] rx_byte
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [7:0] protected_id, [13:8] frame_id, [21:14] data_0,
  //   [29:22] data_1, [37:30] data_2, [45:38] data_3, [53:46] data_4,
  //   [61:54] data_5, [69:62] data_6, [77:70] data_7, [79:78] error_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Frame phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SYNC  = 3'd1;
  localparam logic [2:0] PH_PID   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  localparam logic [3:0] MAX_LEN = 4'(MAX_DATA_BYTES);

  logic [3:0]         data_length_r;
  logic [2:0]         phase_r, phase_nxt;
  logic [3:0]         byte_cnt_r, byte_cnt_nxt;
  logic [3:0]         frame_len_r, frame_len_nxt;
  lfr_pkg::byte_t     sync_r, sync_nxt;
  lfr_pkg::byte_t     pid_r, pid_nxt;
  lfr_pkg::byte_t     sum_r, sum_nxt;
  lfr_pkg::byte_t     store_r [lfr_pkg::DATA_SLOTS];
  lfr_pkg::byte_t     store_nxt [lfr_pkg::DATA_SLOTS];
  logic               out_valid_r;
  lfr_pkg::result_t   out_data_r, result;
  logic               in_beat;
  logic               emit;
  logic               cfg_wr;
  logic [3:0]         len_clamped;
  lfr_pkg::byte_t     rx;
  logic [1:0]         err;

  assign rx        = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign emit      = in_beat && (phase_r == PH_CHECK);

  // APB register access
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == lfr_pkg::REG_DATA_LENGTH) ?
                      {28'd0, data_length_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_length_r <= 4'd2;
    end else if (cfg_wr && (cfg_paddr[2] == lfr_pkg::REG_DATA_LENGTH)) begin
      data_length_r <= cfg_pwdata[3:0];
    end
  end

  // Length latched at the break: zero reads as one, capped at the maximum
  always_comb begin
    if (data_length_r == 4'd0) begin
      len_clamped = 4'd1;
    end else if (data_length_r > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end else begin
      len_clamped = data_length_r;
    end
  end

  // Error priority: sync, then parity, then checksum
  always_comb begin
    if (sync_r != lfr_pkg::SYNC_BYTE) begin
      err = lfr_pkg::ERR_SYNC;
    end else if (lfr_pkg::pid_with_parity(pid_r) != pid_r) begin
      err = lfr_pkg::ERR_PARITY;
    end else if (~sum_r != rx) begin
      err = lfr_pkg::ERR_CHECKSUM;
    end else begin
      err = lfr_pkg::ERR_NONE;
    end
  end

  always_comb begin
    result.protected_id = pid_r;
    result.frame_id     = pid_r[5:0];
    result.data_0       = store_r[0];
    result.data_1       = store_r[1];
    result.data_2       = store_r[2];
    result.data_3       = store_r[3];
    result.data_4       = store_r[4];
    result.data_5       = store_r[5];
    result.data_6       = store_r[6];
    result.data_7       = store_r[7];
    result.error_code   = err;
  end

  // Frame sequencer, one byte per beat
  always_comb begin
    phase_nxt     = phase_r;
    byte_cnt_nxt  = byte_cnt_r;
    frame_len_nxt = frame_len_r;
    sync_nxt      = sync_r;
    pid_nxt       = pid_r;
    sum_nxt       = sum_r;
    store_nxt     = store_r;
    unique case (phase_r)
      PH_SYNC: begin
        sync_nxt  = rx;
        phase_nxt = PH_PID;
      end
      PH_PID: begin
        pid_nxt      = rx;
        sum_nxt      = rx;
        byte_cnt_nxt = 4'd0;
        phase_nxt    = PH_DATA;
      end
      PH_DATA: begin
        store_nxt[byte_cnt_r[2:0]] = rx;
        sum_nxt      = lfr_pkg::add_carry(sum_r, rx);
        byte_cnt_nxt = byte_cnt_r + 4'd1;
        if (byte_cnt_nxt >= frame_len_r) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_nxt = PH_IDLE;
      end
      default: begin
        // idle and unused codes: wait for a break
        phase_nxt = PH_IDLE;
        if (rx == lfr_pkg::BREAK_BYTE) begin
          phase_nxt     = PH_SYNC;
          byte_cnt_nxt  = 4'd0;
          sync_nxt      = 8'd0;
          pid_nxt       = 8'd0;
          sum_nxt       = 8'd0;
          frame_len_nxt = len_clamped;
          for (int i = 0; i < lfr_pkg::DATA_SLOTS; i++) begin
            store_nxt[i] = 8'd0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      byte_cnt_r  <= 4'd0;
      frame_len_r <= 4'd0;
    end else if (in_beat) begin
      phase_r     <= phase_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      frame_len_r <= frame_len_nxt;
    end
  end

  // Frame payload, always written by a break before it is read
  always_ff @(posedge clk) begin
    if (in_beat) begin
      sync_r  <= sync_nxt;
      pid_r   <= pid_nxt;
      sum_r   <= sum_nxt;
      store_r <= store_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `ASSERT_CLK(a_check_emits, clk, rst_n, (in_tvalid && in_tready && phase_r == PH_CHECK) |=> out_tvalid, "checksum beat gave no result")
  `ASSERT_CLK(a_stall_blocks, clk, rst_n, (out_tvalid && !out_tready) |-> !in_tready, "input taken while result stalled")
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, (phase_r == PH_DATA) && (byte_cnt_r >= frame_len_r), "data count past frame length")
  `ASSERT_NEVER(a_len_range, clk, rst_n, (phase_r != PH_IDLE) && ((frame_len_r == 4'd0) || (frame_len_r > MAX_LEN)), "frame length out of range")

endmodule

[tb/lin_frame_receiver_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lin_frame_receiver_top_tb
// Self-checking bench for the LIN frame receiver. A byte queue feeds the
// input stream. A shadow of the frame decoder predicts each result beat from
// the accepted bytes, and a monitor compares every result field against it.
// Frames are mostly well formed with random content, mixed with sync, parity,
// checksum and length faults and idle noise. The run spans several
// data_length settings, including out-of-range ones, under varied
// backpressure.
// ----------------------------------------------------------------------------
module lin_frame_receiver_top_tb;

  localparam int MAX_DATA      = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int BEATS_PER_SET = 70;

  // APB byte addresses
  localparam logic [2:0] ADDR_DATA_LENGTH = {lfr_pkg::REG_DATA_LENGTH, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

  typedef enum logic [2:0] {
    RX_IDLE, RX_SYNC, RX_PID, RX_DATA, RX_CHECK
  } rx_phase_t;

  typedef enum int {
    FAULT_NONE, FAULT_SYNC, FAULT_PARITY, FAULT_SUM, FAULT_LENGTH
  } frame_fault_t;

  // One decoded frame; data[i] is data byte i
  typedef struct packed {
    logic [1:0]       err;
    logic [7:0][7:0]  data;
    logic [5:0]       id;
    lfr_pkg::byte_t   pid;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;          // see field list at the DUT port
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lin_frame_receiver_top #(.MAX_DATA_BYTES(MAX_DATA)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Stimulus and expectations
  lfr_pkg::byte_t rx_bytes_q[$];
  frame_result_t  expected_frames_q[$];
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             frame_beats_queued = 0;

  // Decoder shadow
  rx_phase_t       rx_phase = RX_IDLE;
  logic [3:0]      rx_count = 4'd0;
  logic [3:0]      rx_len = 4'd0;
  lfr_pkg::byte_t  rx_sync = 8'h00;
  lfr_pkg::byte_t  rx_pid = 8'h00;
  lfr_pkg::byte_t  rx_sum = 8'h00;
  logic [7:0][7:0] rx_data = '0;
  logic [3:0]      cfg_data_length = 4'd2;

  // Run statistics
  int beats_in = 0;
  int frames_checked = 0;
  int fail_count = 0;
  int err_seen[4] = '{0, 0, 0, 0};

  // PID from a six-bit identifier with both parity bits
  function automatic lfr_pkg::byte_t lin_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // End-around-carry byte sum
  function automatic lfr_pkg::byte_t carry_add(input lfr_pkg::byte_t a,
                                               input lfr_pkg::byte_t b);
    int s;
    s = int'(a) + int'(b);
    if (s > 255) s = s - 255;
    return lfr_pkg::byte_t'(s);
  endfunction

  // Register value to data bytes per frame
  function automatic logic [3:0] effective_len(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > MAX_DATA) return 4'(MAX_DATA);
    return v;
  endfunction

  function automatic frame_result_t unpack_result(input logic [79:0] d);
    frame_result_t r;
    r.pid  = d[7:0];
    r.id   = d[13:8];
    r.data = d[77:14];
    r.err  = d[79:78];
    return r;
  endfunction

  function automatic string show_result(input frame_result_t r);
    return $sformatf("pid=%02h id=%02h data[7..0]=%016h err=%0d",
                     r.pid, r.id, r.data, r.err);
  endfunction

  // Advance the decoder shadow by one accepted byte
  task automatic track_rx_byte(input lfr_pkg::byte_t b);
    frame_result_t r;
    case (rx_phase)
      RX_SYNC: begin
        rx_sync  = b;
        rx_phase = RX_PID;
      end
      RX_PID: begin
        rx_pid   = b;
        rx_sum   = b;
        rx_count = 4'd0;
        rx_phase = RX_DATA;
      end
      RX_DATA: begin
        rx_data[rx_count[2:0]] = b;
        rx_sum   = carry_add(rx_sum, b);
        rx_count = rx_count + 4'd1;
        if (rx_count >= rx_len) rx_phase = RX_CHECK;
      end
      RX_CHECK: begin
        r.pid  = rx_pid;
        r.id   = rx_pid[5:0];
        r.data = rx_data;
        // sync fault beats parity, parity beats checksum
        if (rx_sync != lfr_pkg::SYNC_BYTE) r.err = lfr_pkg::ERR_SYNC;
        else if (lin_pid(rx_pid[5:0]) != rx_pid) r.err = lfr_pkg::ERR_PARITY;
        else if (lfr_pkg::byte_t'(~rx_sum) != b) r.err = lfr_pkg::ERR_CHECKSUM;
        else r.err = lfr_pkg::ERR_NONE;
        expected_frames_q.push_back(r);
        rx_phase = RX_IDLE;
      end
      default: begin
        rx_phase = RX_IDLE;
        if (b == lfr_pkg::BREAK_BYTE) begin
          rx_phase = RX_SYNC;
          rx_count = 4'd0;
          rx_sync  = 8'h00;
          rx_pid   = 8'h00;
          rx_sum   = 8'h00;
          rx_data  = '0;
          rx_len   = effective_len(cfg_data_length);
        end
      end
    endcase
  endtask

  // Input driver: next byte only once the current beat has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
    end else begin
      if (in_tvalid && in_tready) begin
        track_rx_byte(in_tdata);
        beats_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= rx_bytes_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    string         bad;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_result(out_tdata);
      if (expected_frames_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("[%0t] result beat with none expected: %s", $realtime, show_result(got));
      end else begin
        want = expected_frames_q.pop_front();
        frames_checked++;
        bad = "";
        if (got.pid !== want.pid) bad = {bad, " protected_id"};
        if (got.id !== want.id) bad = {bad, " frame_id"};
        for (int i = 0; i < 8; i++)
          if (got.data[i] !== want.data[i]) bad = {bad, $sformatf(" data_%0d", i)};
        if (got.err !== want.err) bad = {bad, " error_code"};
        if (bad != "") begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] frame %0d mismatch in%s\n  expected %s\n  actual   %s",
                     $realtime, frames_checked, bad, show_result(want), show_result(got));
        end else begin
          err_seen[want.err]++;
        end
      end
    end
  end

  // Break, sync, PID, n data bytes, then checksum xor'd with sum_flip
  task automatic queue_frame_raw(input lfr_pkg::byte_t sync_b, input lfr_pkg::byte_t pid,
                                 input logic [15:0][7:0] payload, input int n,
                                 input lfr_pkg::byte_t sum_flip);
    lfr_pkg::byte_t sum;
    sum = pid;
    rx_bytes_q.push_back(lfr_pkg::BREAK_BYTE);
    rx_bytes_q.push_back(sync_b);
    rx_bytes_q.push_back(pid);
    for (int i = 0; i < n; i++) begin
      rx_bytes_q.push_back(payload[i]);
      sum = carry_add(sum, payload[i]);
    end
    rx_bytes_q.push_back(~sum ^ sum_flip);
    frame_beats_queued += n + 4;
  endtask

  // Random frame content, with one optional fault
  task automatic queue_frame(input int n, input frame_fault_t fault);
    logic [15:0][7:0] payload;
    lfr_pkg::byte_t   pid;
    lfr_pkg::byte_t   sync_b;
    lfr_pkg::byte_t   flip;
    int               pick;
    pid    = lin_pid(6'($urandom()));
    sync_b = lfr_pkg::SYNC_BYTE;
    flip   = 8'h00;
    for (int i = 0; i < 16; i++) begin
      pick = $urandom_range(9);
      payload[i] = (pick == 0) ? 8'h00 :
                   (pick == 1) ? 8'hFF : lfr_pkg::byte_t'($urandom());
    end
    case (fault)
      FAULT_SYNC: begin
        do sync_b = lfr_pkg::byte_t'($urandom()); while (sync_b == lfr_pkg::SYNC_BYTE);
        if ($urandom_range(1)) pid = lfr_pkg::byte_t'($urandom());
      end
      FAULT_PARITY: pid = pid ^ {2'($urandom_range(1, 3)), 6'd0};
      FAULT_SUM:    flip = lfr_pkg::byte_t'($urandom_range(1, 255));
      FAULT_LENGTH: n = $urandom_range(1) ? n + 1 : n - 1;
      default: ;
    endcase
    queue_frame_raw(sync_b, pid, payload, n, flip);
  endtask

  // Mostly clean frames at the current length, some faulty, some idle noise
  task automatic queue_random_traffic(input int target);
    int           start;
    int           pick;
    frame_fault_t fault;
    start = frame_beats_queued;
    while (frame_beats_queued - start < target) begin
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 3))
          rx_bytes_q.push_back(lfr_pkg::byte_t'($urandom_range(1, 255)));
      pick = $urandom_range(99);
      if (pick < 60)      fault = FAULT_NONE;
      else if (pick < 70) fault = FAULT_SYNC;
      else if (pick < 80) fault = FAULT_PARITY;
      else if (pick < 90) fault = FAULT_SUM;
      else                fault = FAULT_LENGTH;
      queue_frame(int'(effective_len(cfg_data_length)), fault);
    end
    // non-zero tail closes any misaligned frame, so the set ends idle
    repeat (12) rx_bytes_q.push_back(lfr_pkg::byte_t'($urandom_range(1, 255)));
  endtask

  // Wait for all bytes accepted and all results delivered, then settle
  task automatic drain;
    do @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_tvalid || expected_frames_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] wdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if ((addr >> 2) == 3'(lfr_pkg::REG_DATA_LENGTH)) cfg_data_length = wdata[3:0];
  endtask

  // Main sequence
  initial begin
    logic [3:0]       len_sets[6];
    logic [15:0][7:0] payload;
    len_sets = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd15, 4'd5};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 16;
    recv_stall_pct = 59;

    // Directed: idle noise, clean frame with zero/FF data, sync fault that
    // also has bad parity, parity fault with zero checksum, checksum fault
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(lfr_pkg::SYNC_BYTE);
    payload = '0;
    payload[1] = 8'hFF;
    queue_frame_raw(lfr_pkg::SYNC_BYTE, lin_pid(6'h3F), payload, 2, 8'h00);
    payload[0] = 8'hFF;
    payload[1] = 8'h00;
    queue_frame_raw(8'h00, 8'h12, payload, 2, 8'h00);
    payload[0] = 8'hA5;
    payload[1] = 8'h5A;
    queue_frame_raw(lfr_pkg::SYNC_BYTE, 8'h00, payload, 2, 8'h00);
    payload[0] = 8'hFF;
    payload[1] = 8'hFF;
    queue_frame_raw(lfr_pkg::SYNC_BYTE, lin_pid(6'h00), payload, 2, 8'h01);

    for (int s = 0; s < 6; s++) begin
      if (s > 0) begin
        drain();
        apb_write(ADDR_DATA_LENGTH, {28'($urandom()), len_sets[s]});
        // writes to an unmapped register must leave data_length alone
        if (s == 3) apb_write(ADDR_UNMAPPED, $urandom());
      end
      if (s == 2) begin
        send_idle_pct  = 59;
        recv_stall_pct = 16;
      end else if (s == 4) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      queue_random_traffic(BEATS_PER_SET);
    end

    drain();
    $display("Covered %0d input beats and %0d frame results over data_length 2, 1, 8, 0, 15, 5",
             beats_in, frames_checked);
    $display("Clean %0d, sync fault %0d, parity fault %0d, checksum fault %0d; mismatches %0d",
             err_seen[lfr_pkg::ERR_NONE], err_seen[lfr_pkg::ERR_SYNC],
             err_seen[lfr_pkg::ERR_PARITY], err_seen[lfr_pkg::ERR_CHECKSUM],
             fail_count);
    if (fail_count == 0 && expected_frames_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_frames_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
